@@ src/nalf_pkg.sv @@
`timescale 1ns / 1ps

package nalf_pkg;

    // Largest number of rate indices the probe pass may cycle through
    localparam int MAX_RATES = 8;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_WINDOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT    = 3'd4;

    // Register reset values
    localparam logic [3:0]  RATE_COUNT_RST    = 4'd1;
    localparam logic [15:0] SILENCE_LIMIT_RST = 16'd3000;
    localparam logic [7:0]  MAX_LINE_LEN_RST  = 8'd120;
    localparam logic [15:0] PROBE_WINDOW_RST  = 16'd1200;
    localparam logic [15:0] RETRY_WAIT_RST    = 16'd1000;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Effective cap on the rate count: never above 8 nor below 1
    localparam int RATE_CAP_I = (MAX_RATES < 8) ? ((MAX_RATES < 1) ? 1 : MAX_RATES) : 8;
    localparam logic [3:0] RATE_CAP = 4'(RATE_CAP_I);

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       line_end;
        logic       locked;
        logic [2:0] rate_index;
        logic       switch_rate;
    } res_item_t;

endpackage

@@ src/nmea_autobaud_line_framer_unit.sv @@
`timescale 1ns / 1ps

// NMEA auto-baud probe and line framer.
// Input channel (in_valid/in_ready/in_data): one item per received serial byte
// (opcode 0) or per millisecond tick (opcode 1). Result channel
// (res_valid/res_ready/res_data): exactly one item per input item, in order.
// After reset the block probes rate indices, one probe window of ticks each,
// and locks on the first '$'. While locked, bytes stream out (CR dropped, LF
// closes a non-empty line, over-long lines are cut); too many ticks with no
// '$' sends it back to probing. switch_rate tells the receiver to reopen.
// Pipeline: an input register, then the result register. The state update
// happens when an item moves from the input register to the result register.
// The result is registered; throughput is one item per cycle while res_ready
// stays high, so the receiver takes each result as it comes.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only once both are full, and rises again in the same
// cycle res_ready returns. Reset (rst_n low, asynchronous) empties both
// stages, restores register defaults and restarts probing at index 0.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once;
// indexes past the last register are ignored.
module nmea_autobaud_line_framer_unit
    import nalf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_item_t             res_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [3:0]  rate_count_reg;
    logic [15:0] silence_limit_reg;
    logic [7:0]  max_line_len_reg;
    logic [15:0] probe_window_reg;
    logic [15:0] retry_wait_reg;

    // Pipeline registers
    logic      in_full_reg;
    in_item_t  in_hold_reg;
    logic      res_valid_reg;
    res_item_t res_data_reg;
    res_item_t res_data_next;

    // Framer state
    logic        lock_flag_reg,     lock_flag_next;
    logic [2:0]  cur_idx_reg,       cur_idx_next;
    logic [15:0] window_count_reg,  window_count_next;
    logic        retry_phase_reg,   retry_phase_next;
    logic [15:0] silence_count_reg, silence_count_next;
    logic [7:0]  line_length_reg,   line_length_next;

    logic        advance;
    logic [3:0]  eff_rates;
    logic [16:0] win_inc;
    logic [15:0] sil_sat;
    logic [8:0]  len_inc;

    // Item moves from the input register into the result register
    assign advance   = in_full_reg && (!res_valid_reg || res_ready);
    assign in_ready  = !in_full_reg || advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Rate count clamped into 1..RATE_CAP
    always_comb
    begin
        if (rate_count_reg == 4'd0)
            eff_rates = 4'd1;
        else if (rate_count_reg > RATE_CAP)
            eff_rates = RATE_CAP;
        else
            eff_rates = rate_count_reg;
    end

    assign win_inc = {1'b0, window_count_reg} + 17'd1;
    assign len_inc = {1'b0, line_length_reg} + 9'd1;
    // Saturating increment of the silence counter
    assign sil_sat = (silence_count_reg == 16'hFFFF) ? silence_count_reg
                                                     : silence_count_reg + 16'd1;

    always_comb
    begin
        lock_flag_next     = lock_flag_reg;
        cur_idx_next       = cur_idx_reg;
        window_count_next  = window_count_reg;
        retry_phase_next   = retry_phase_reg;
        silence_count_next = silence_count_reg;
        line_length_next   = line_length_reg;
        res_data_next      = '0;

        if (!lock_flag_reg) begin
            if (!retry_phase_reg) begin
                // probing one rate index
                if (in_hold_reg.opcode == OP_BYTE) begin
                    if (in_hold_reg.rx_byte == CH_DOLLAR) begin
                        lock_flag_next     = 1'b1;
                        silence_count_next = '0;
                        window_count_next  = '0;
                    end
                end else if (win_inc >= {1'b0, probe_window_reg}) begin
                    window_count_next = '0;
                    if ({1'b0, cur_idx_reg} + 4'd1 < eff_rates) begin
                        cur_idx_next              = cur_idx_reg + 3'd1;
                        res_data_next.switch_rate = 1'b1;
                    end else if (retry_wait_reg == 16'd0) begin
                        cur_idx_next              = '0;
                        res_data_next.switch_rate = 1'b1;
                    end else begin
                        retry_phase_next = 1'b1;
                    end
                end else begin
                    window_count_next = win_inc[15:0];
                end
            end else if (in_hold_reg.opcode == OP_TICK) begin
                // waiting after a failed pass
                if (win_inc >= {1'b0, retry_wait_reg}) begin
                    retry_phase_next          = 1'b0;
                    window_count_next         = '0;
                    cur_idx_next              = '0;
                    res_data_next.switch_rate = 1'b1;
                end else begin
                    window_count_next = win_inc[15:0];
                end
            end
        end else if (in_hold_reg.opcode == OP_BYTE) begin
            if (in_hold_reg.rx_byte == CH_DOLLAR)
                silence_count_next = '0;
            if (in_hold_reg.rx_byte == CH_CR) begin
                // dropped
            end else if (in_hold_reg.rx_byte == CH_LF) begin
                if (line_length_reg != 8'd0) begin
                    res_data_next.line_end = 1'b1;
                    line_length_next       = '0;
                end
            end else begin
                res_data_next.out_valid = 1'b1;
                res_data_next.out_byte  = in_hold_reg.rx_byte;
                if (len_inc > {1'b0, max_line_len_reg}) begin
                    res_data_next.line_end = 1'b1;
                    line_length_next       = '0;
                end else begin
                    line_length_next = len_inc[7:0];
                end
            end
        end else begin
            // tick while locked: count silence, reprobe past the limit
            silence_count_next = sil_sat;
            if (sil_sat > silence_limit_reg) begin
                lock_flag_next            = 1'b0;
                cur_idx_next              = '0;
                window_count_next         = '0;
                retry_phase_next          = 1'b0;
                silence_count_next        = '0;
                res_data_next.switch_rate = 1'b1;
            end
        end

        res_data_next.locked     = lock_flag_next;
        res_data_next.rate_index = cur_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rate_count_reg    <= RATE_COUNT_RST;
            silence_limit_reg <= SILENCE_LIMIT_RST;
            max_line_len_reg  <= MAX_LINE_LEN_RST;
            probe_window_reg  <= PROBE_WINDOW_RST;
            retry_wait_reg    <= RETRY_WAIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RATE_COUNT:    rate_count_reg    <= cfg_data[3:0];
                REG_SILENCE_LIMIT: silence_limit_reg <= cfg_data;
                REG_MAX_LINE_LEN:  max_line_len_reg  <= cfg_data[7:0];
                REG_PROBE_WINDOW:  probe_window_reg  <= cfg_data;
                REG_RETRY_WAIT:    retry_wait_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg       <= 1'b0;
            res_valid_reg     <= 1'b0;
            lock_flag_reg     <= 1'b0;
            cur_idx_reg       <= '0;
            window_count_reg  <= '0;
            retry_phase_reg   <= 1'b0;
            silence_count_reg <= '0;
            line_length_reg   <= '0;
        end else begin
            if (in_ready)
                in_full_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            if (advance) begin
                lock_flag_reg     <= lock_flag_next;
                cur_idx_reg       <= cur_idx_next;
                window_count_reg  <= window_count_next;
                retry_phase_reg   <= retry_phase_next;
                silence_count_reg <= silence_count_next;
                line_length_reg   <= line_length_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_hold_reg <= in_data;
        if (advance)
            res_data_reg <= res_data_next;
    end

`ifndef NO_ASSERTIONS
    // line characters and line ends only leave while locked
    a_char_locked: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_data_reg.out_valid || res_data_reg.line_end)
        |-> res_data_reg.locked)
        else $error("line output while not locked");

    // framer state moves only when an item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(lock_flag_reg) && $stable(cur_idx_reg)
                     && $stable(line_length_reg))
        else $error("framer state changed without an item");

    // result shows the state the item left behind
    a_res_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_data_reg.locked == lock_flag_reg)
                    && (res_data_reg.rate_index == cur_idx_reg))
        else $error("result does not match framer state");
`endif

endmodule

@@ dv/nalf_framer_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result of the
// probe/framer and compares it with what comes out, in order.
module nalf_framer_checker
    import nalf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  res_item_t             res_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expected_count
);

    // register copies
    logic [3:0]  rate_count_q;
    logic [15:0] silence_limit_q;
    logic [7:0]  max_len_q;
    logic [15:0] window_len_q;
    logic [15:0] retry_len_q;

    // framer state
    logic        is_locked;
    logic [2:0]  rate_idx;
    logic [15:0] window_cnt;
    logic        in_retry;
    logic [15:0] silence_cnt;
    logic [7:0]  line_len;

    res_item_t   expected_q[$];
    int          mismatches;

    function automatic int rates_tried();
        int cap;
        int n;
        cap = (MAX_RATES < 8) ? MAX_RATES : 8;
        if (cap < 1)
            cap = 1;
        n = int'(rate_count_q);
        if (n < 1)
            n = 1;
        if (n > cap)
            n = cap;
        return n;
    endfunction

    // Advances the state by one item and returns the result it causes.
    function automatic res_item_t frame_next(input in_item_t item);
        res_item_t   r;
        logic [16:0] next_cnt;
        logic [8:0]  next_len;
        r = '0;
        next_cnt = {1'b0, window_cnt} + 17'd1;
        if (!is_locked)
        begin
            if (!in_retry)
            begin
                if (item.opcode == OP_BYTE)
                begin
                    if (item.rx_byte == CH_DOLLAR)
                    begin
                        is_locked   = 1'b1;
                        silence_cnt = '0;
                        window_cnt  = '0;
                    end
                end
                else if (next_cnt >= {1'b0, window_len_q})
                begin
                    window_cnt = '0;
                    if (int'(rate_idx) + 1 < rates_tried())
                    begin
                        rate_idx      = rate_idx + 3'd1;
                        r.switch_rate = 1'b1;
                    end
                    else if (retry_len_q == '0)
                    begin
                        rate_idx      = '0;
                        r.switch_rate = 1'b1;
                    end
                    else
                        in_retry = 1'b1;
                end
                else
                    window_cnt = next_cnt[15:0];
            end
            else if (item.opcode == OP_TICK)
            begin
                if (next_cnt >= {1'b0, retry_len_q})
                begin
                    in_retry      = 1'b0;
                    window_cnt    = '0;
                    rate_idx      = '0;
                    r.switch_rate = 1'b1;
                end
                else
                    window_cnt = next_cnt[15:0];
            end
        end
        else if (item.opcode == OP_BYTE)
        begin
            if (item.rx_byte == CH_DOLLAR)
                silence_cnt = '0;
            if (item.rx_byte == CH_LF)
            begin
                if (line_len != '0)
                begin
                    r.line_end = 1'b1;
                    line_len   = '0;
                end
            end
            else if (item.rx_byte != CH_CR)
            begin
                next_len    = {1'b0, line_len} + 9'd1;
                r.out_valid = 1'b1;
                r.out_byte  = item.rx_byte;
                if (next_len > {1'b0, max_len_q})
                begin
                    r.line_end = 1'b1;
                    line_len   = '0;
                end
                else
                    line_len = next_len[7:0];
            end
        end
        else
        begin
            if (silence_cnt != 16'hFFFF)
                silence_cnt = silence_cnt + 16'd1;
            if (silence_cnt > silence_limit_q)
            begin
                is_locked     = 1'b0;
                rate_idx      = '0;
                window_cnt    = '0;
                in_retry      = 1'b0;
                silence_cnt   = '0;
                r.switch_rate = 1'b1;
            end
        end
        r.locked     = is_locked;
        r.rate_index = rate_idx;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            rate_count_q    = RATE_COUNT_RST;
            silence_limit_q = SILENCE_LIMIT_RST;
            max_len_q       = MAX_LINE_LEN_RST;
            window_len_q    = PROBE_WINDOW_RST;
            retry_len_q     = RETRY_WAIT_RST;
            is_locked       = 1'b0;
            rate_idx        = '0;
            window_cnt      = '0;
            in_retry        = 1'b0;
            silence_cnt     = '0;
            line_len        = '0;
            mismatches      = 0;
            expected_q.delete();
            fail_count     <= 0;
            expected_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE_COUNT:    rate_count_q    = cfg_data[3:0];
                    REG_SILENCE_LIMIT: silence_limit_q = cfg_data;
                    REG_MAX_LINE_LEN:  max_len_q       = cfg_data[7:0];
                    REG_PROBE_WINDOW:  window_len_q    = cfg_data;
                    REG_RETRY_WAIT:    retry_len_q     = cfg_data;
                    default:           ;
                endcase
            end
            // pop before push: a result can never belong to an item taken this edge
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with nothing expected: %h", res_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_valid", want.out_valid, res_data.out_valid);
                    check_field("out_byte", want.out_byte, res_data.out_byte);
                    check_field("line_end", want.line_end, res_data.line_end);
                    check_field("locked", want.locked, res_data.locked);
                    check_field("rate_index", want.rate_index, res_data.rate_index);
                    check_field("switch_rate", want.switch_rate, res_data.switch_rate);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(frame_next(in_data));
            fail_count     <= mismatches;
            expected_count <= expected_q.size();
        end
    end

endmodule

@@ dv/nmea_autobaud_line_framer_unit_tb.sv @@
`timescale 1ns / 1ps

// Top of the bench: clock, reset, stimulus and verdict. All prediction and
// comparison lives in the checker instantiated next to the block.
module nmea_autobaud_line_framer_unit_tb;
    import nalf_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  res_valid;
    logic                  res_ready;
    res_item_t             res_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int expected_count;

    // chance, in percent, that each side idles on a given cycle
    int send_idle_pct;
    int recv_idle_pct;
    int sent_items;
    // current max_line_len, so sentences can straddle the cut point
    int line_cap;

    nmea_autobaud_line_framer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nalf_framer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready is re-rolled every cycle, so stalls land on every phase
    // of the block's pipeline.
    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #3_000_000;
        $display("nmea_autobaud_line_framer_unit_tb NOT OK");
        $finish;
    end

    // Offer one item, with a random run of idle cycles in front of it, and
    // return at the edge where it is taken. Valid is left high; the next call
    // or end_burst decides whether it drops.
    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t item;
        item.opcode  = OP_BYTE;
        item.rx_byte = b;
        send_item(item);
    endtask

    // rx_byte is don't-care on a tick; randomize it anyway
    task automatic send_ticks(input int n);
        in_item_t item;
        item.opcode = OP_TICK;
        repeat (n)
        begin
            item.rx_byte = 8'($urandom_range(255));
            send_item(item);
        end
    endtask

    // Called right at the acceptance edge of the last item of a burst.
    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected result is back, then allow slack for the
    // two-stage pipeline. expected_count is registered, hence the first edge.
    task automatic drain();
        do
            @(posedge clk);
        while (expected_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // Only called with the block idle: after reset or after drain().
    task automatic apply_settings(input int rates, input int silence, input int max_len,
                                  input int window, input int retry);
        put_reg(REG_RATE_COUNT, rates);
        put_reg(REG_SILENCE_LIMIT, silence);
        put_reg(REG_MAX_LINE_LEN, max_len);
        put_reg(REG_PROBE_WINDOW, window);
        put_reg(REG_RETRY_WAIT, retry);
        cfg_we   <= 1'b0;
        line_cap  = max_len;
    endtask

    // A well-formed sentence with random body: '$', body, usually CR LF.
    // Ticks sneak in between bytes now and then. Mostly short bodies, some
    // long enough to run past the line cut.
    task automatic send_sentence();
        int hi;
        int len;
        send_byte(CH_DOLLAR);
        hi = line_cap + 3;
        if ($urandom_range(9) != 0 && hi > 24)
            hi = 24;
        len = $urandom_range(hi, 0);
        repeat (len)
        begin
            if ($urandom_range(11) == 0)
                send_ticks($urandom_range(3, 1));
            if ($urandom_range(15) == 0)
                send_byte(8'($urandom_range(255)));
            else
                send_byte(8'($urandom_range(8'h7E, 8'h20)));
        end
        if ($urandom_range(3) != 0)
            send_byte(CH_CR);
        if ($urandom_range(7) != 0)
            send_byte(CH_LF);
    endtask

    // Line noise: random bytes and ticks mixed.
    task automatic send_noise();
        in_item_t item;
        repeat ($urandom_range(6, 1))
        begin
            item.opcode  = 1'($urandom_range(1));
            item.rx_byte = 8'($urandom_range(255));
            send_item(item);
        end
    endtask

    // Mostly sentences; tick runs push the probe windows, retry wait and the
    // silence timeout along.
    task automatic run_random(input int count);
        int start;
        int pick;
        start = sent_items;
        while (sent_items - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_sentence();
            else if (pick < 85)
                send_noise();
            else
                send_ticks($urandom_range(25, 1));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        res_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        sent_items    = 0;
        line_cap      = int'(MAX_LINE_LEN_RST);
        send_idle_pct = 24;
        recv_idle_pct = 87;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: a byte ignored while probing, the '$' that
        // locks (consumed), extreme bytes, CR dropped, a '$' passed through once
        // locked, LF closing a line, LF on an empty line, then a silence tick.
        send_ticks(1);
        send_byte(8'h41);
        send_byte(CH_DOLLAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_DOLLAR);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_ticks(1);
        end_burst();
        drain();

        // Directed, tight settings: silence timeout to reprobe, walk all three
        // rate indices, a byte and a '$' ignored during probe and retry, the
        // retry wait back to index 0, lock, then a line cut for length.
        apply_settings(3, 3, 2, 2, 2);
        send_ticks(3);
        send_ticks(2);
        send_byte(8'h78);
        send_ticks(4);
        send_byte(CH_DOLLAR);
        send_ticks(2);
        send_byte(CH_DOLLAR);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        send_byte(CH_LF);
        end_burst();
        drain();

        // Random, short windows and a few rates.
        apply_settings(4, 20, 8, 3, 5);
        run_random(150);
        end_burst();
        drain();

        // Sender now the slow side.
        send_idle_pct = 87;
        recv_idle_pct = 24;

        // All zero: rate count 0 acts as 1, zero window acts as one tick, zero
        // retry goes straight back, every byte cuts, any tick drops the lock.
        apply_settings(0, 0, 0, 0, 0);
        run_random(80);
        end_burst();
        drain();

        // Rate count past the cap, longest lines, one-tick windows, longest
        // retry wait.
        apply_settings(15, 12, 255, 1, 65535);
        run_random(80);
        end_burst();
        drain();

        // No idling from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Silence limit at its top: lock, then a run of ticks that leaves the
        // lock in place.
        apply_settings(8, 65535, 120, 65535, 3);
        run_random(80);
        send_byte(CH_DOLLAR);
        send_ticks(40);
        send_byte(8'h5A);
        send_byte(CH_LF);
        end_burst();
        drain();

        apply_settings(2, 30, 16, 4, 1);
        run_random(80);
        end_burst();
        drain();

        if (fail_count == 0)
            $display("nmea_autobaud_line_framer_unit_tb OK");
        else
            $display("nmea_autobaud_line_framer_unit_tb NOT OK");
        $finish;
    end

endmodule
